FILE: hw/rtl/vsi_pkg.sv
`timescale 1ns / 1ps
// Package for the vertex snap/insert indexer: payload structs, register
// indexes and fixed widths. No dependencies.
package vsi_pkg;

    localparam int unsigned COORD_W = 10;
    localparam int unsigned FRAC_W  = 16;
    localparam int unsigned CIDX_W  = 3;
    localparam int unsigned CDATA_W = 10;

    localparam logic [CIDX_W-1:0] CFG_GROUP_ID    = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_TOLERANCE   = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_LIMIT_LEFT  = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_LIMIT_RIGHT = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_LIMIT_UP    = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_LIMIT_DOWN  = 3'd5;

    typedef struct packed {
        logic [9:0] point_x;
        logic [9:0] point_y;
    } t_in;

    typedef struct packed {
        logic [7:0]  vertex_index;
        logic        reused;
        logic [15:0] u_frac;
        logic [15:0] v_frac;
        logic [8:0]  group_vertices;
        logic [9:0]  index_slot;
        logic        vertex_store_full;
        logic        index_list_full;
    } t_out;

endpackage

FILE: hw/rtl/vertex_snap_insert_indexer.sv
`timescale 1ns / 1ps
// Vertex snap/insert indexer top level. Uses vsi_pkg and vsi_div.
// Per item, the vertex memory scan (one entry per cycle, N = stored vertices)
//   and the two 16-step divides all run; o_strobe comes once all have finished.
// Throughput: one item at a time; next start is taken the cycle after o_strobe.
// Reset (synchronous, active low) empties both stores and restores the registers.
// Results last one cycle; the receiver cannot stall.
module vertex_snap_insert_indexer
    import vsi_pkg::*;
#(
    parameter int unsigned VERTEX_DEPTH = 256,
    parameter int unsigned INDEX_DEPTH  = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_in                i_point,
    output logic               o_strobe,
    output t_out               o_result,
    input  logic               i_cfg_we,
    input  logic [CIDX_W-1:0]  i_cfg_idx,
    input  logic [CDATA_W-1:0] i_cfg_data
);

    localparam int unsigned VW = $clog2(VERTEX_DEPTH);
    localparam int unsigned IW = $clog2(INDEX_DEPTH);
    localparam logic [VW:0] VCNT_FULL = (VW+1)'(VERTEX_DEPTH);
    localparam logic [IW:0] ICNT_FULL = (IW+1)'(INDEX_DEPTH);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    logic [7:0]         r_group_id, r_tol;
    logic [COORD_W-1:0] r_left, r_right, r_up, r_down;

    logic [1:0]         r_st, n_st;
    logic [VW:0]        r_count, r_addr, r_gcnt;
    logic [IW:0]        r_icount;
    logic [COORD_W-1:0] r_px, r_py;
    logic               r_found, r_rvld;
    logic [VW-1:0]      r_vidx, r_ridx;
    logic [27:0]        r_rdata;

    logic [27:0]        vmem [VERTEX_DEPTH];
    logic [7:0]         imem [INDEX_DEPTH];

    logic               accept, issue, fin_go, du_done, dv_done;
    logic [FRAC_W-1:0]  du_q, dv_q;
    logic [COORD_W-1:0] rd_x, rd_y, dx, dy;
    logic [7:0]         rd_g;
    logic               g_hit, w_hit;
    logic               new_ok, have, ins_ok;
    logic [VW-1:0]      vidx_sel;
    logic [FRAC_W-1:0]  u_sel, v_sel;

    assign busy   = r_st != ST_IDLE;
    assign accept = start && !busy;
    assign issue  = r_st == ST_SCAN;
    assign fin_go = r_st == ST_FIN && du_done && dv_done;

    vsi_div u_div_u (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_num   (i_point.point_x - r_left),
        .i_den   (r_right - r_left),
        .o_done  (du_done),
        .o_quot  (du_q)
    );

    vsi_div u_div_v (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_num   (i_point.point_y - r_up),
        .i_den   (r_down - r_up),
        .o_done  (dv_done),
        .o_quot  (dv_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_id <= 8'd0;
            r_tol      <= 8'd10;
            r_left     <= 10'd0;
            r_right    <= 10'd650;
            r_up       <= 10'd0;
            r_down     <= 10'd650;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GROUP_ID:    r_group_id <= i_cfg_data[7:0];
                CFG_TOLERANCE:   r_tol      <= i_cfg_data[7:0];
                CFG_LIMIT_LEFT:  r_left     <= i_cfg_data;
                CFG_LIMIT_RIGHT: r_right    <= i_cfg_data;
                CFG_LIMIT_UP:    r_up       <= i_cfg_data;
                CFG_LIMIT_DOWN:  r_down     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // vertex entry: {group, y, x}
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rdata <= vmem[r_addr[VW-1:0]];
        end
        if (fin_go && new_ok) begin
            vmem[r_count[VW-1:0]] <= {r_group_id, r_py, r_px};
        end
        if (fin_go && ins_ok) begin
            imem[r_icount[IW-1:0]] <= 8'(vidx_sel);
        end
    end

    always_comb begin
        rd_x  = r_rdata[9:0];
        rd_y  = r_rdata[19:10];
        rd_g  = r_rdata[27:20];
        dx    = (rd_x > r_px) ? rd_x - r_px : r_px - rd_x;
        dy    = (rd_y > r_py) ? rd_y - r_py : r_py - rd_y;
        g_hit = rd_g == r_group_id;
        w_hit = g_hit && dx < {2'b00, r_tol} && dy < {2'b00, r_tol};
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE:  if (accept) n_st = (r_count == '0) ? ST_FIN : ST_SCAN;
            ST_SCAN:  if (r_addr + 1'b1 == r_count) n_st = ST_DRAIN;
            ST_DRAIN: n_st = ST_FIN;
            ST_FIN:   if (fin_go) n_st = ST_IDLE;
            default:  n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_IDLE;
            r_count  <= '0;
            r_icount <= '0;
            r_rvld   <= 1'b0;
            r_found  <= 1'b0;
            r_gcnt   <= '0;
            r_addr   <= '0;
        end else begin
            r_st   <= n_st;
            r_rvld <= issue;
            if (accept) begin
                r_px    <= i_point.point_x;
                r_py    <= i_point.point_y;
                r_addr  <= '0;
                r_found <= 1'b0;
                r_gcnt  <= '0;
            end
            if (issue) begin
                r_ridx <= r_addr[VW-1:0];
                r_addr <= r_addr + 1'b1;
            end
            if (r_rvld) begin
                if (g_hit) r_gcnt <= r_gcnt + 1'b1;
                if (w_hit && !r_found) begin
                    r_found <= 1'b1;
                    r_vidx  <= r_ridx;
                end
            end
            if (fin_go) begin
                if (new_ok) r_count  <= r_count + 1'b1;
                if (ins_ok) r_icount <= r_icount + 1'b1;
            end
        end
    end

    always_comb begin
        new_ok   = !r_found && r_count < VCNT_FULL;
        have     = r_found || new_ok;
        ins_ok   = have && r_icount < ICNT_FULL;
        vidx_sel = r_found ? r_vidx : r_count[VW-1:0];
        if (r_px <= r_left)       u_sel = '0;
        else if (r_px >= r_right) u_sel = '1;
        else                      u_sel = du_q;
        if (r_py <= r_up)         v_sel = '0;
        else if (r_py >= r_down)  v_sel = '1;
        else                      v_sel = dv_q;

        o_strobe                   = fin_go;
        o_result.vertex_index      = have ? 8'(vidx_sel) : 8'd0;
        o_result.reused            = r_found;
        o_result.u_frac            = new_ok ? u_sel : '0;
        o_result.v_frac            = new_ok ? v_sel : '0;
        o_result.group_vertices    = 9'(r_gcnt + (VW+1)'(new_ok));
        o_result.index_slot        = ins_ok ? 10'(r_icount[IW-1:0]) : 10'd0;
        o_result.vertex_store_full = !have;
        o_result.index_list_full   = have && !ins_ok;
    end

endmodule

FILE: hw/rtl/vsi_div.sv
`timescale 1ns / 1ps
// Restoring serial divider: (num << 16) / den, one quotient bit per cycle.
// Uses vsi_pkg; expects num < den for a meaningful quotient.
module vsi_div
    import vsi_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [COORD_W-1:0] i_num,
    input  logic [COORD_W-1:0] i_den,
    output logic               o_done,
    output logic [FRAC_W-1:0]  o_quot
);

    localparam int unsigned CNT_W = $clog2(FRAC_W);

    logic               r_busy, n_busy;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [COORD_W:0]   r_rem, n_rem;
    logic [COORD_W-1:0] r_den, n_den;
    logic [FRAC_W-1:0]  r_quot, n_quot;
    logic [COORD_W:0]   shifted;
    logic               take;

    always_comb begin
        shifted = {r_rem[COORD_W-1:0], 1'b0};
        take    = shifted >= {1'b0, r_den};
        n_busy  = r_busy;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_den   = r_den;
        n_quot  = r_quot;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = {1'b0, i_num};
            n_den  = i_den;
            n_quot = '0;
        end else if (r_busy) begin
            n_rem  = take ? shifted - {1'b0, r_den} : shifted;
            n_quot = {r_quot[FRAC_W-2:0], take};
            n_cnt  = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(FRAC_W - 1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_quot <= n_quot;
    end

    assign o_done = !r_busy;
    assign o_quot = r_quot;

endmodule

FILE: hw/rtl/vsi_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the vertex snap/insert indexer, bound to the top.
// Uses vsi_pkg.
module vsi_chk
    import vsi_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_strobe,
    input t_out o_result
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after a transfer in");

    a_strobe_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result outside an item");

    a_strobe_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> (!busy && !o_strobe))
        else $error("item not closed after its result");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !(o_result.vertex_store_full &&
                       (o_result.reused || o_result.index_list_full)))
        else $error("inconsistent result flags");

endmodule

bind vertex_snap_insert_indexer vsi_chk u_vsi_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

FILE: sim/tb_vertex_snap_insert_indexer.sv
`timescale 1ns / 1ps
// Testbench for vertex_snap_insert_indexer: directed and random points, checked
// against an in-bench snap/insert predictor. Depends on vsi_pkg and the RTL top.
module tb_vertex_snap_insert_indexer;
    import vsi_pkg::*;

    localparam int unsigned VTX_DEPTH    = 256;
    localparam int unsigned IDX_DEPTH    = 1024;
    localparam int unsigned STALL_LIMIT  = 5000;
    localparam int unsigned DRAIN_CYCLES = 300;
    localparam int unsigned RAND_PHASES  = 8;
    localparam int unsigned PHASE_POINTS = 241;
    localparam int unsigned SHOW_LIMIT   = 10;
    localparam logic [CIDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CIDX_W-1:0] CFG_SPARE_7 = 3'd7;

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    t_in                i_point = '0;
    logic               o_strobe;
    t_out               o_result;
    logic               i_cfg_we = 1'b0;
    logic [CIDX_W-1:0]  i_cfg_idx = CFG_GROUP_ID;
    logic [CDATA_W-1:0] i_cfg_data = '0;

    // predictor state
    logic [9:0]  vtx_x   [VTX_DEPTH];
    logic [9:0]  vtx_y   [VTX_DEPTH];
    logic [7:0]  vtx_grp [VTX_DEPTH];
    int unsigned vtx_fill  = 0;
    int unsigned slot_fill = 0;
    logic [7:0]  cur_group = 8'd0;
    logic [7:0]  cur_tol   = 8'd10;
    logic [9:0]  lim_left  = 10'd0;
    logic [9:0]  lim_right = 10'd650;
    logic [9:0]  lim_up    = 10'd0;
    logic [9:0]  lim_down  = 10'd650;

    t_in         point_queue[$];
    t_in         placed[$];
    t_out        expected_results[$];
    logic        point_taken = 1'b0;
    int          idle_pct = 0;
    int unsigned mismatch_count = 0;
    int unsigned stall_cycles = 0;

    vertex_snap_insert_indexer #(
        .VERTEX_DEPTH(VTX_DEPTH),
        .INDEX_DEPTH (IDX_DEPTH)
    ) u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_point   (i_point),
        .o_strobe  (o_strobe),
        .o_result  (o_result),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned coord_dist(logic [9:0] a, logic [9:0] b);
        return (a > b) ? int'(a - b) : int'(b - a);
    endfunction

    function automatic logic [15:0] tex_q16(logic [9:0] p, logic [9:0] lo, logic [9:0] hi);
        logic [31:0] num;
        if (p <= lo) return 16'h0000;
        if (p >= hi) return 16'hFFFF;
        num = 32'(p - lo) << 16;
        return 16'(num / 32'(hi - lo));
    endfunction

    function automatic t_out place_point(t_in pt);
        t_out        r;
        logic        hit;
        int unsigned members;
        r = '0;
        hit = 1'b0;
        members = 0;
        for (int unsigned k = 0; k < vtx_fill; k++) begin
            if (!hit && vtx_grp[k] == cur_group
                    && coord_dist(vtx_x[k], pt.point_x) < cur_tol
                    && coord_dist(vtx_y[k], pt.point_y) < cur_tol) begin
                hit = 1'b1;
                r.vertex_index = 8'(k);
            end
        end
        if (hit) begin
            r.reused = 1'b1;
        end else if (vtx_fill >= VTX_DEPTH) begin
            r.vertex_store_full = 1'b1;
        end else begin
            r.vertex_index = 8'(vtx_fill);
            vtx_x[vtx_fill] = pt.point_x;
            vtx_y[vtx_fill] = pt.point_y;
            vtx_grp[vtx_fill] = cur_group;
            vtx_fill++;
            r.u_frac = tex_q16(pt.point_x, lim_left, lim_right);
            r.v_frac = tex_q16(pt.point_y, lim_up, lim_down);
        end
        if (!r.vertex_store_full) begin
            if (slot_fill >= IDX_DEPTH) begin
                r.index_list_full = 1'b1;
            end else begin
                r.index_slot = 10'(slot_fill);
                slot_fill++;
            end
        end
        for (int unsigned k = 0; k < vtx_fill; k++) begin
            if (vtx_grp[k] == cur_group) members++;
        end
        r.group_vertices = 9'(members);
        return r;
    endfunction

    function automatic string show_result(t_out r);
        return $sformatf("idx=%0d reused=%0b u=%0d v=%0d count=%0d slot=%0d vfull=%0b ifull=%0b",
                         r.vertex_index, r.reused, r.u_frac, r.v_frac, r.group_vertices,
                         r.index_slot, r.vertex_store_full, r.index_list_full);
    endfunction

    function automatic logic [9:0] clamp_coord(int c);
        if (c < 0) return 10'd0;
        if (c > 1023) return 10'd1023;
        return 10'(c);
    endfunction

    function automatic int jitter(int reach);
        return int'($urandom_range(2 * reach)) - reach;
    endfunction

    // mostly points around earlier ones, so snaps and near misses both occur
    function automatic t_in next_point();
        t_in pt;
        t_in base;
        int  reach;
        if (placed.size() != 0 && $urandom_range(99) < 80) begin
            base = placed[$urandom_range(placed.size() - 1)];
            reach = ($urandom_range(99) < 80) ? int'(cur_tol) - 1 : int'(cur_tol) + 1;
            if (reach < 0) reach = 0;
            pt.point_x = clamp_coord(int'(base.point_x) + jitter(reach));
            pt.point_y = clamp_coord(int'(base.point_y) + jitter(reach));
        end else begin
            pt.point_x = 10'($urandom_range(1023));
            pt.point_y = 10'($urandom_range(1023));
        end
        return pt;
    endfunction

    function automatic void queue_xy(logic [9:0] x, logic [9:0] y);
        t_in pt;
        pt.point_x = x;
        pt.point_y = y;
        point_queue.push_back(pt);
        placed.push_back(pt);
    endfunction

    function automatic void apply_reg(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] data);
        case (idx)
            CFG_GROUP_ID:    cur_group = data[7:0];
            CFG_TOLERANCE:   cur_tol   = data[7:0];
            CFG_LIMIT_LEFT:  lim_left  = data;
            CFG_LIMIT_RIGHT: lim_right = data;
            CFG_LIMIT_UP:    lim_up    = data;
            CFG_LIMIT_DOWN:  lim_down  = data;
            default: ;
        endcase
    endfunction

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        apply_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        do begin
            @(posedge i_clk);
        end while (point_queue.size() != 0 || start || expected_results.size() != 0);
    endtask

    task automatic write_limits(input logic [9:0] l, input logic [9:0] r,
                                input logic [9:0] u, input logic [9:0] d);
        write_reg(CFG_LIMIT_LEFT, l);
        write_reg(CFG_LIMIT_RIGHT, r);
        write_reg(CFG_LIMIT_UP, u);
        write_reg(CFG_LIMIT_DOWN, d);
    endtask

    task automatic setup_phase(input int k);
        logic [9:0] lo;
        logic [9:0] hi;
        logic [9:0] lo2;
        logic [9:0] hi2;
        int         pick;
        case (k)
            0: begin
                write_reg(CFG_GROUP_ID, 10'h0FF);
                write_reg(CFG_TOLERANCE, 10'h0FF);
                write_limits(10'd0, 10'd1023, 10'd0, 10'd1023);
            end
            RAND_PHASES - 2: begin
                write_reg(CFG_GROUP_ID, 10'h300);
                write_reg(CFG_TOLERANCE, 10'd1);
                write_limits(10'd1023, 10'd1023, 10'd1, 10'd0);
            end
            default: begin
                pick = ($urandom_range(99) < 80) ? int'($urandom_range(3))
                                                 : int'($urandom_range(255));
                write_reg(CFG_GROUP_ID, {2'($urandom_range(3)), 8'(pick)});
                pick = $urandom_range(99);
                if (pick < 5) begin
                    write_reg(CFG_TOLERANCE, 10'd0);
                end else if (pick < 10) begin
                    write_reg(CFG_TOLERANCE, 10'd255);
                end else begin
                    write_reg(CFG_TOLERANCE, 10'($urandom_range(40, 2)));
                end
                lo  = 10'($urandom_range(900));
                hi  = lo + 10'($urandom_range(1023 - lo, 1));
                lo2 = 10'($urandom_range(900));
                hi2 = lo2 + 10'($urandom_range(1023 - lo2, 1));
                if ($urandom_range(99) < 15) begin
                    write_limits(hi, lo, lo2, hi2);
                end else if ($urandom_range(99) < 15) begin
                    write_limits(lo, hi, hi2, lo2);
                end else begin
                    write_limits(lo, hi, lo2, hi2);
                end
            end
        endcase
    endtask

    // sender: next point at the falling edge once the previous transfer is done
    always @(negedge i_clk) begin
        if (!start || point_taken) begin
            if (i_rst_n && point_queue.size() != 0 && int'($urandom_range(99)) >= idle_pct) begin
                i_point <= point_queue.pop_front();
                start   <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        point_taken <= i_rst_n && start && !busy;
        if (i_rst_n) begin
            if (o_strobe) begin
                if (expected_results.size() == 0) begin
                    if (mismatch_count < SHOW_LIMIT)
                        $display("unexpected result: %s", show_result(o_result));
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (want.vertex_index !== o_result.vertex_index
                            || want.reused !== o_result.reused
                            || want.u_frac !== o_result.u_frac
                            || want.v_frac !== o_result.v_frac
                            || want.group_vertices !== o_result.group_vertices
                            || want.index_slot !== o_result.index_slot
                            || want.vertex_store_full !== o_result.vertex_store_full
                            || want.index_list_full !== o_result.index_list_full) begin
                        if (mismatch_count < SHOW_LIMIT)
                            $display("mismatch at %0t: expected %s, got %s", $realtime,
                                     show_result(want), show_result(o_result));
                        mismatch_count++;
                    end
                end
            end
            if (start && !busy) begin
                expected_results.push_back(place_point(i_point));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe === 1'b1) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_vertex_snap_insert_indexer failed");
            $finish;
        end
    end

    initial begin
        t_in pt;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: snap window edges and texture saturation
        queue_xy(10'd0, 10'd0);
        queue_xy(10'd0, 10'd0);
        queue_xy(10'd9, 10'd9);
        queue_xy(10'd10, 10'd0);
        queue_xy(10'd0, 10'd10);
        queue_xy(10'd1023, 10'd1023);
        queue_xy(10'd1014, 10'd1014);
        queue_xy(10'd1013, 10'd1023);
        queue_xy(10'd650, 10'd649);
        queue_xy(10'd1, 10'd651);
        queue_xy(10'd325, 10'd325);
        wait_drained();

        // zero tolerance, masked group, reversed and empty limits, spare indexes
        write_reg(CFG_GROUP_ID, 10'h3FF);
        write_reg(CFG_TOLERANCE, 10'h000);
        write_limits(10'd700, 10'd300, 10'd400, 10'd400);
        write_reg(CFG_SPARE_6, 10'h3FF);
        write_reg(CFG_SPARE_7, 10'h155);
        queue_xy(10'd0, 10'd0);
        queue_xy(10'd0, 10'd0);
        queue_xy(10'd800, 10'd401);
        queue_xy(10'd700, 10'd400);
        wait_drained();

        write_reg(CFG_GROUP_ID, 10'h300);
        write_reg(CFG_TOLERANCE, 10'h3FF);
        queue_xy(10'd500, 10'd500);
        queue_xy(10'd1023, 10'd0);
        wait_drained();

        for (int k = 0; k < RAND_PHASES; k++) begin
            setup_phase(k);
            case (k % 4)
                1: idle_pct = 47;
                2: idle_pct = 23;
                default: idle_pct = 0;
            endcase
            for (int n = 0; n < PHASE_POINTS; n++) begin
                pt = next_point();
                queue_xy(pt.point_x, pt.point_y);
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("tb_vertex_snap_insert_indexer passed");
        end else begin
            $display("tb_vertex_snap_insert_indexer failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/vsi_pkg.sv
hw/rtl/vsi_div.sv
hw/rtl/vertex_snap_insert_indexer.sv
hw/rtl/vsi_chk.sv
sim/tb_vertex_snap_insert_indexer.sv
